FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MWO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MWO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg
// Waveform codes and register map of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_kind_t;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_WAVEFORM_KIND = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd2;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  // Q30 fixed-point constants for the sine table build
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

FILE: sv/mwo_sine_rom.sv
// ----------------------------------------------------------------------------
// mwo_sine_rom
// Full-wave sine ROM with one registered read port, built at elaboration.
// ----------------------------------------------------------------------------
module mwo_sine_rom #(
  parameter int SAMPLE_BITS = 16,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
  output logic signed [SAMPLE_BITS-1:0]        rd_data
);

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [TABLE_DEPTH];

  localparam logic signed [63:0] FULL_SCALE = 64'sd1 <<< (SAMPLE_BITS - 1);

  // Quarter-wave Taylor series in Q30, mirrored and negated per quadrant
  function automatic rom_t build_rom();
    rom_t               tbl;
    logic [63:0]        u;
    logic [63:0]        quad;
    logic [63:0]        frac;
    logic [63:0]        g;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      u    = (64'(k) << 32) / 64'(TABLE_DEPTH);
      quad = (u >> 30) & 64'd3;
      frac = u & (mwo_pkg::Q30_ONE - 64'd1);
      g    = quad[0] ? (mwo_pkg::Q30_ONE - frac) : frac;
      x    = (g * mwo_pkg::HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      s = unsigned'(sum);
      v = signed'((s + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS));
      if (v > FULL_SCALE - 64'sd1) begin
        v = FULL_SCALE - 64'sd1;
      end
      tbl[k] = SAMPLE_BITS'((quad >= 64'd2) ? -v : v);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [SAMPLE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/multi_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// An accepted request is registered in stage one (phase, last flag, sine ROM read), then in the out_* registers.
// Throughput: one request per cycle unless out_tready stalls; phase add plus registered sine ROM read.
// Reset (sync, rst_n low): phase and index zero, sine / step 0 / burst 1, empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_waveform_oscillator #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // restart at bit 0
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,
  // sample at bits SAMPLE_BITS-1:0, zero padded to whole bytes
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mwo_pkg::APB_AW-1:0]           cfg_paddr,
  input  logic [mwo_pkg::APB_DW-1:0]           cfg_pwdata,
  output logic [mwo_pkg::APB_DW-1:0]           cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int PROD_W = PHASE_BITS + ADDR_W + 1;

  localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W + 1)'(TABLE_DEPTH);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Configuration
  mwo_pkg::wave_kind_t           kind_r;
  logic [mwo_pkg::STEP_W-1:0]    phase_step_r;
  logic [mwo_pkg::COUNT_W-1:0]   sample_count_r;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  // Accumulator state
  logic [PHASE_BITS-1:0]         phase_acc_r;
  logic [PHASE_BITS-1:0]         phase_acc_nxt;
  logic [COUNT_BITS-1:0]         sample_index_r;
  logic [COUNT_BITS-1:0]         sample_index_nxt;
  logic [PHASE_BITS-1:0]         phase_cur;
  logic [COUNT_BITS-1:0]         index_cur;
  logic [COUNT_BITS:0]           index_inc;
  logic [COUNT_BITS-1:0]         count_eff;
  logic [PHASE_BITS-1:0]         step_eff;
  logic                          last_nxt;
  logic [PROD_W-1:0]             table_prod;
  logic [ADDR_W-1:0]             table_addr;

  // Pipeline
  logic                          in_acc;
  logic                          out_adv;
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [PHASE_BITS-1:0]         s1_phase_r;
  logic                          s1_last_r;
  logic signed [SAMPLE_BITS-1:0] sine_q;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  // Waveform shaping
  logic [PHASE_BITS-1:0]             tri_w;
  logic [PHASE_BITS:0]               tri_neg;
  logic [PHASE_BITS-1:0]             tri_m;
  logic [PHASE_BITS+SAMPLE_BITS-1:0] tri_wide;
  logic [SAMPLE_BITS:0]              tri_raw;
  logic [PHASE_BITS+SAMPLE_BITS-1:0] saw_wide;
  logic [SAMPLE_BITS-1:0]            saw_raw;
  logic signed [SAMPLE_BITS-1:0]     sample_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      mwo_pkg::REG_WAVEFORM_KIND: cfg_prdata = mwo_pkg::APB_DW'(kind_r);
      mwo_pkg::REG_PHASE_STEP:    cfg_prdata = mwo_pkg::APB_DW'(phase_step_r);
      mwo_pkg::REG_SAMPLE_COUNT:  cfg_prdata = mwo_pkg::APB_DW'(sample_count_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- accumulator
  assign in_acc    = in_tvalid & in_tready;
  assign out_adv   = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | out_adv;

  assign phase_cur = in_tdata[0] ? '0 : phase_acc_r;
  assign index_cur = in_tdata[0] ? '0 : sample_index_r;
  assign index_inc = {1'b0, index_cur} + (COUNT_BITS + 1)'(1);
  assign count_eff = COUNT_BITS'(sample_count_r);
  assign step_eff  = PHASE_BITS'(phase_step_r);
  // a zero count compares as always reached, which makes every sample last
  assign last_nxt  = index_inc >= {1'b0, count_eff};

  assign phase_acc_nxt    = last_nxt ? '0 : phase_cur + step_eff;
  assign sample_index_nxt = last_nxt ? '0 : index_inc[COUNT_BITS-1:0];

  assign table_prod = PROD_W'(phase_cur) * PROD_W'(DEPTH_W);
  assign table_addr = table_prod[PHASE_BITS +: ADDR_W];

  assign s1_valid_nxt = in_acc | (s1_valid_r & ~out_adv);

  mwo_sine_rom #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (table_addr),
    .rd_data (sine_q)
  );

  // --------------------------------------------------------------- shaping
  assign tri_w    = {s1_phase_r[PHASE_BITS-2:0], 1'b0};
  assign tri_neg  = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, tri_w};
  assign tri_m    = (tri_w <= {1'b1, {(PHASE_BITS - 1){1'b0}}}) ? tri_w
                                                               : tri_neg[PHASE_BITS-1:0];
  assign tri_wide = {tri_m, {SAMPLE_BITS{1'b0}}} >> (PHASE_BITS - 1);
  assign tri_raw  = tri_wide[SAMPLE_BITS:0];
  assign saw_wide = {s1_phase_r, {SAMPLE_BITS{1'b0}}} >> PHASE_BITS;
  assign saw_raw  = saw_wide[SAMPLE_BITS-1:0];

  always_comb begin
    unique case (kind_r)
      mwo_pkg::WAVE_SINE: sample_nxt = sine_q;
      mwo_pkg::WAVE_SQUARE: begin
        sample_nxt = ((s1_phase_r != '0) && !s1_phase_r[PHASE_BITS-1]) ? SMP_MAX : SMP_MIN;
      end
      mwo_pkg::WAVE_TRIANGLE: begin
        // subtract full scale by flipping the top bit; the peak saturates
        sample_nxt = tri_raw[SAMPLE_BITS] ? SMP_MAX
                   : {~tri_raw[SAMPLE_BITS-1], tri_raw[SAMPLE_BITS-2:0]};
      end
      mwo_pkg::WAVE_SAWTOOTH: begin
        sample_nxt = {~saw_raw[SAMPLE_BITS-1], saw_raw[SAMPLE_BITS-2:0]};
      end
      default: sample_nxt = SMP_MIN;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r         <= mwo_pkg::WAVE_SINE;
      phase_step_r   <= '0;
      sample_count_r <= mwo_pkg::COUNT_W'(1);
      phase_acc_r    <= '0;
      sample_index_r <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          mwo_pkg::REG_WAVEFORM_KIND: begin
            kind_r <= mwo_pkg::wave_kind_t'(cfg_pwdata[mwo_pkg::KIND_W-1:0]);
          end
          mwo_pkg::REG_PHASE_STEP:   phase_step_r   <= cfg_pwdata[mwo_pkg::STEP_W-1:0];
          mwo_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_pwdata[mwo_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_acc_r    <= phase_acc_nxt;
        sample_index_r <= sample_index_nxt;
      end
      s1_valid_r <= s1_valid_nxt;
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_phase_r <= phase_cur;
      s1_last_r  <= last_nxt;
    end
    if (out_adv) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'($unsigned(out_sample_r));
  assign out_tlast  = out_last_r;

  // ------------------------------------------------------------ assertions
  `MWO_ASSERT(a_last_rewinds,
              in_acc && last_nxt |=> phase_acc_r == '0 && sample_index_r == '0,
              "burst end did not rewind phase and index")
  `MWO_ASSERT(a_square_levels,
              out_valid_r && kind_r == mwo_pkg::WAVE_SQUARE |->
                out_sample_r == SMP_MAX || out_sample_r == SMP_MIN,
              "square sample off the two levels")
  `MWO_ASSERT(a_s1_held, s1_valid_r && !out_adv |=> s1_valid_r,
              "stalled request dropped from stage one")
  `MWO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r,
                     "pipeline not empty after reset")

endmodule
